/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds at the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants shared by the table linear interpolator files.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CFG_W       = 7;
  localparam int N_W         = ($clog2(TABLE_DEPTH + 1) > CFG_W) ?
                               $clog2(TABLE_DEPTH + 1) : CFG_W;
  localparam int SLOT_W      = 6;
  localparam int ANGLE_W     = 16;
  localparam int LIFT_W      = 16;
  localparam int ENTRY_W     = ANGLE_W + LIFT_W;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int DCNT_W      = $clog2(PROD_W);

  typedef enum logic {
    MODE_LOAD,
    MODE_QUERY
  } mode_t;

  typedef enum logic [1:0] {
    STAT_LOADED,
    STAT_EXACT,
    STAT_INTERP,
    STAT_OOR
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_FINISH
  } state_t;

  typedef struct packed {
    mode_t                     mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [ANGLE_W-1:0] angle_value;
    logic signed [LIFT_W-1:0]  lift_value;
  } in_item_t;

  typedef struct packed {
    logic signed [LIFT_W-1:0] lift_out;
    status_t                  status;
  } out_item_t;

endpackage

/* rtl/tli_in_if.sv */
// ----------------------------------------------------------------------------
// tli_in_if
// Input item channel: valid/ready handshake with one input item as payload.
// ----------------------------------------------------------------------------
interface tli_in_if;
  logic              valid;
  logic              ready;
  tli_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tli_out_if.sv */
// ----------------------------------------------------------------------------
// tli_out_if
// Result channel: valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface tli_out_if;
  logic               valid;
  logic               ready;
  tli_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tli_cfg_if.sv */
// ----------------------------------------------------------------------------
// tli_cfg_if
// Configuration write channel carrying the entries-in-use register value.
// ----------------------------------------------------------------------------
interface tli_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tli_pkg::CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tli_ram.sv */
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/table_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Breakpoint table of angle/lift pairs answering queries by linear interpolation.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch. A load item (mode 0) writes one breakpoint
// into the table and answers status 0 with a zero lift. A query item
// (mode 1) searches up to entries_in_use slots and answers an exact
// match, an interpolated lift, or out of range. Every item gives exactly one
// result transfer on out_ch. The cfg_ch channel writes entries_in_use; it is
// always ready and is meant to be written while no item is in flight.
// Flow: a load goes from the idle state to the finish state, which moves it
// into the result register. A query first checks the last searched entry,
// then scans the entries in order; a bracketed query then passes through a
// multiply step, a restoring divide (one quotient bit per cycle from one
// subtractor) and a fix-up step. The table RAM's single read port sets the
// scan rate. One item is processed at a time: in_ch.ready is high only while
// the sequencer is idle, so the next item is accepted in the cycle after the
// result register loads at the earliest. The result register lets a new
// item enter while a result waits; if the receiver stalls, the next result
// waits in its final state until the register frees up. Reset clears the
// sequencer, the result valid flag and entries_in_use; the table contents
// are undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_linear_interpolator (
  input  logic  clk,
  input  logic  rst_n,
  tli_in_if.sink    in_ch,
  tli_out_if.source out_ch,
  tli_cfg_if.sink   cfg_ch
);

  import tli_pkg::*;

  // Sequencer and working registers.
  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          entries_r;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [IDX_W-1:0]          last_r, last_nxt;
  logic signed [ANGLE_W-1:0] q_r, q_nxt;
  logic signed [ANGLE_W-1:0] prev_a_r, prev_a_nxt;
  logic signed [LIFT_W-1:0]  prev_l_r, prev_l_nxt;
  logic signed [DIFF_W-1:0]  dq_r, dq_nxt;
  logic signed [DIFF_W-1:0]  dl_r, dl_nxt;
  logic signed [DIFF_W-1:0]  den_r, den_nxt;
  logic signed [LIFT_W-1:0]  base_r, base_nxt;
  logic [PROD_W-1:0]         num_r, num_nxt;
  logic [DIFF_W-1:0]         rem_r, rem_nxt;
  logic [DIFF_W-1:0]         dmag_r, dmag_nxt;
  logic                      neg_r, neg_nxt;
  logic [DCNT_W-1:0]         dcnt_r, dcnt_nxt;
  logic signed [LIFT_W-1:0]  res_lift_r, res_lift_nxt;
  status_t                   res_stat_r, res_stat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  // Table RAM: angle in the upper half, lift in the lower half of each word.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  tli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshakes.
  logic in_fire, out_fire, out_free, cfg_fire;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // Effective table length, saturated to the table depth.
  logic [N_W-1:0] n_eff;
  assign n_eff = (N_W'(entries_r) > N_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH)
                                                       : N_W'(entries_r);

  // Entry currently presented by the RAM read port.
  logic signed [ANGLE_W-1:0] cur_a;
  logic signed [LIFT_W-1:0]  cur_l;
  assign cur_a = ram_rdata[ENTRY_W-1:LIFT_W];
  assign cur_l = ram_rdata[LIFT_W-1:0];

  // Scan decisions: the entry on the read port against q_r and prev_a_r, plus index checks.
  logic is_query, table_empty, above_last, below_first, bracket, exact, at_end;
  logic den_zero;
  assign is_query    = (in_ch.data.mode == MODE_QUERY);
  assign table_empty = (n_eff == '0);
  assign above_last  = (q_r > cur_a);
  assign below_first = (idx_r == '0) && (q_r < cur_a);
  assign bracket     = (idx_r != '0) && (cur_a > q_r);
  assign exact       = (cur_a == q_r);
  assign at_end      = (idx_r == last_r);
  assign den_zero    = (cur_a == prev_a_r);

  // Arithmetic helpers for the multiply, divide and fix-up steps.
  logic signed [PROD_W-1:0]   prod;
  logic [DIFF_W:0]            rem_sh;
  logic                       div_ge;
  logic                       div_done;
  logic signed [PROD_W:0]     quo_ext;
  logic signed [PROD_W:0]     quo_signed;
  logic signed [PROD_W+1:0]   sum;
  logic signed [PROD_W+1:0]   lift_max;
  logic signed [PROD_W+1:0]   lift_min;

  assign prod       = dq_r * dl_r;
  assign rem_sh     = {rem_r, num_r[PROD_W-1]};
  assign div_ge     = (rem_sh >= {1'b0, dmag_r});
  assign div_done   = (dcnt_r == DCNT_W'(PROD_W - 1));
  assign quo_ext    = $signed({1'b0, num_r});
  assign quo_signed = neg_r ? -quo_ext : quo_ext;
  assign sum        = (PROD_W + 2)'(base_r) + (PROD_W + 2)'(quo_signed);
  assign lift_max   = (PROD_W + 2)'(2 ** (LIFT_W - 1) - 1);
  assign lift_min   = -(PROD_W + 2)'(2 ** (LIFT_W - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_query && !table_empty) begin
            state_nxt = ST_LAST;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_LAST: begin
        state_nxt = above_last ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        priority if (below_first) begin
          state_nxt = ST_FINISH;
        end else if (bracket) begin
          state_nxt = den_zero ? ST_FINISH : ST_MUL;
        end else if (exact || at_end) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = div_done ? ST_FIX : ST_DIV;
      end
      ST_FIX: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = out_free ? ST_IDLE : ST_FINISH;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    q_nxt         = q_r;
    prev_a_nxt    = prev_a_r;
    prev_l_nxt    = prev_l_r;
    dq_nxt        = dq_r;
    dl_nxt        = dl_r;
    den_nxt       = den_r;
    base_nxt      = base_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    dcnt_nxt      = dcnt_r;
    res_lift_nxt  = res_lift_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(in_ch.data.slot);
    ram_wdata     = {in_ch.data.angle_value, in_ch.data.lift_value};
    ram_raddr     = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        // Start the read of the last searched entry for the range check.
        ram_raddr = IDX_W'(n_eff - 1'b1);
        if (in_fire) begin
          q_nxt        = in_ch.data.angle_value;
          last_nxt     = IDX_W'(n_eff - 1'b1);
          idx_nxt      = '0;
          res_lift_nxt = '0;
          if (!is_query) begin
            // A slot beyond the table depth is dropped but still answered.
            ram_we       = (32'(in_ch.data.slot) < 32'(TABLE_DEPTH));
            res_stat_nxt = STAT_LOADED;
          end else begin
            res_stat_nxt = STAT_OOR;
          end
        end
      end
      ST_LAST: begin
        // Last entry is on the read port; the first entry is requested next.
        ram_raddr = '0;
        idx_nxt   = '0;
      end
      ST_SCAN: begin
        ram_raddr = idx_r + 1'b1;
        priority if (below_first) begin
          res_stat_nxt = STAT_OOR;
        end else if (bracket) begin
          dq_nxt       = DIFF_W'(q_r) - DIFF_W'(prev_a_r);
          dl_nxt       = DIFF_W'(cur_l) - DIFF_W'(prev_l_r);
          den_nxt      = DIFF_W'(cur_a) - DIFF_W'(prev_a_r);
          base_nxt     = prev_l_r;
          res_stat_nxt = STAT_OOR;
        end else if (exact) begin
          res_lift_nxt = cur_l;
          res_stat_nxt = STAT_EXACT;
        end else if (at_end) begin
          res_stat_nxt = STAT_OOR;
        end else begin
          idx_nxt    = idx_r + 1'b1;
          prev_a_nxt = cur_a;
          prev_l_nxt = cur_l;
        end
      end
      ST_MUL: begin
        // Split numerator and divisor into sign and magnitude.
        num_nxt  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        dmag_nxt = den_r[DIFF_W-1] ? DIFF_W'(-den_r) : DIFF_W'(den_r);
        neg_nxt  = prod[PROD_W-1] ^ den_r[DIFF_W-1];
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_nxt  = div_ge ? DIFF_W'(rem_sh - {1'b0, dmag_r}) : rem_sh[DIFF_W-1:0];
        num_nxt  = {num_r[PROD_W-2:0], div_ge};
        dcnt_nxt = dcnt_r + 1'b1;
      end
      ST_FIX: begin
        priority if (sum > lift_max) begin
          res_lift_nxt = lift_max[LIFT_W-1:0];
        end else if (sum < lift_min) begin
          res_lift_nxt = lift_min[LIFT_W-1:0];
        end else begin
          res_lift_nxt = sum[LIFT_W-1:0];
        end
        res_stat_nxt = STAT_INTERP;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.lift_out = res_lift_r;
          out_data_nxt.status   = res_stat_r;
        end
      end
      default: begin
        ram_raddr = idx_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      entries_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        entries_r <= cfg_ch.data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    q_r        <= q_nxt;
    prev_a_r   <= prev_a_nxt;
    prev_l_r   <= prev_l_nxt;
    dq_r       <= dq_nxt;
    dl_r       <= dl_nxt;
    den_r      <= den_nxt;
    base_r     <= base_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dmag_r     <= dmag_nxt;
    neg_r      <= neg_nxt;
    dcnt_r     <= dcnt_nxt;
    res_lift_r <= res_lift_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // A waiting result whose status carries no lift.
  logic zero_lift_stat;
  assign zero_lift_stat = out_valid_r && (out_data_r.status == STAT_LOADED ||
                                          out_data_r.status == STAT_OOR);

  // An accepted query takes the sequencer out of the idle state.
  `ASSERT_NEXT(a_query_busy, clk, rst_n, in_fire && is_query, state_r != ST_IDLE)
  // Loads and out-of-range answers always carry a zero lift.
  `ASSERT_IMPL(a_zero_lift, clk, rst_n, zero_lift_stat, out_data_r.lift_out == '0)
  // The scan never runs past the last searched entry.
  `ASSERT_IMPL(a_scan_bound, clk, rst_n, state_r == ST_SCAN, idx_r <= last_r)
  // The divider stops after one step per numerator bit.
  `ASSERT_IMPL(a_div_bound, clk, rst_n, state_r == ST_DIV, dcnt_r <= DCNT_W'(PROD_W - 1))

endmodule
